[hdl/ffba_pkg.sv]
// Shared constants, codes and types of the first-fit block allocator.
// No dependencies; imported by ffba_alu and the top level of the allocator.
`default_nettype none

package ffba_pkg;

  // Default sizing of the arena and the block table
  localparam int ARENA_BYTES_DEF     = 2048;
  localparam int HEADER_BYTES_DEF    = 32;
  localparam int MIN_SPLIT_BYTES_DEF = 16;
  localparam int MAX_BLOCKS_DEF      = 64;

  // Fixed field widths of the stream words
  localparam int SIZE_W   = 11;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 16;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_GRANT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADOFF = 2'd3;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_WR_REM,
    S_RESP
  } ffba_state_t;

  // Verdict of the compare unit on one table entry
  typedef struct packed {
    logic hit;    // entry answers the request
    logic split;  // entry is large enough to be cut
  } ffba_verdict_t;

endpackage

`default_nettype wire

[hdl/ffba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the allocator's block table.
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/ffba_alu.sv]
// Shared compare and add unit: judges one block table entry against the request.
// Depends on ffba_pkg for the request kinds and the verdict struct.
`default_nettype none

module ffba_alu #(
  parameter int AW = 11,
  parameter int CW = 13,
  parameter int HEADER_BYTES = 32
) (
  input  wire logic                   kind,
  input  wire logic [AW-1:0]          hdr,
  input  wire logic [AW-1:0]          size,
  input  wire logic                   used,
  input  wire logic [CW-1:0]          req,
  input  wire logic [CW-1:0]          reqh,
  input  wire logic [CW-1:0]          need,
  input  wire logic [CW-1:0]          tgt,
  input  wire logic                   tgt_ok,
  output      ffba_pkg::ffba_verdict_t verdict,
  output      logic [CW-1:0]          grant,
  output      logic [AW-1:0]          rem_hdr,
  output      logic [AW-1:0]          rem_size
);
  import ffba_pkg::*;

  logic [CW-1:0] hdr_w;
  logic [CW-1:0] size_w;

  assign hdr_w  = CW'(hdr);
  assign size_w = CW'(size);

  always_comb begin
    verdict = '0;
    if (kind == KIND_FREE) begin
      verdict.hit = tgt_ok && (hdr_w == tgt);
    end else begin
      verdict.hit   = !used && (size_w >= req);
      verdict.split = size_w >= need;
    end
  end

  assign grant    = hdr_w + CW'(HEADER_BYTES);
  assign rem_hdr  = AW'(hdr_w + reqh);
  assign rem_size = AW'(size_w - reqh);

endmodule

`default_nettype wire

[hdl/first_fit_block_allocator_unit.sv]
// Top level of the first-fit block allocator: sequencer, block table and result register.
// Depends on ffba_pkg, ffba_ram and ffba_alu.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: kind; tdata: req_size, release_offset
//  m_*     | out | m_tvalid/m_tready  | tdata: status, grant_offset
//
// Sequence: the idle state accepts the word, then the request walks the block table
// one entry at a time (RAM read, then compare) up to the first hit or the last entry.
// A split shifts each block above the hit up one slot (read, then write), then
// writes the remainder; the response state loads the result register once it is free.
// Reset: rst clears control state, then the init state writes the whole-arena free
// block into entry 0 before s_tready rises.
// Stalls: s_tready is high only while idle; a held result in the output
// register does not block acceptance, but the next result waits for it.
`default_nettype none

module first_fit_block_allocator_unit #(
  parameter int ARENA_BYTES     = ffba_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES    = ffba_pkg::HEADER_BYTES_DEF,
  parameter int MIN_SPLIT_BYTES = ffba_pkg::MIN_SPLIT_BYTES_DEF,
  parameter int MAX_BLOCKS      = ffba_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output      logic                         s_tready,
  input  wire logic [ffba_pkg::IN_W-1:0]    s_tdata,   // req_size[10:0], release_offset[21:11]
  input  wire logic                         s_tuser,   // kind
  output      logic                         m_tvalid,
  input  wire logic                         m_tready,
  output      logic [ffba_pkg::OUT_W-1:0]   m_tdata    // status[1:0], grant_offset[12:2]
);
  import ffba_pkg::*;

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int NW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = ((AW > 12) ? AW : 12) + 1;
  localparam int EW = 2 * AW + 1;

  ffba_state_t state, state_next;

  // Control and request registers
  logic [NW-1:0]       count;
  logic [NW-1:0]       idx;      // search position, then index of the hit
  logic [NW-1:0]       jdx;      // destination slot of the shift sweep
  logic                kind_r;
  logic [CW-1:0]       req_r;
  logic [CW-1:0]       reqh_r;   // request plus one header
  logic [CW-1:0]       need_r;   // smallest block worth splitting
  logic [CW-1:0]       tgt_r;    // header offset wanted by a free
  logic                tgt_ok_r;
  logic [EW-1:0]       rem_r;
  logic [STATUS_W-1:0] status_r;
  logic [SIZE_W-1:0]   grant_r;

  // Block table port
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_rdata;

  // Compare unit
  logic [AW-1:0]       ent_hdr;
  logic [AW-1:0]       ent_size;
  logic                ent_used;
  ffba_verdict_t       verdict;
  logic [CW-1:0]       alu_grant;
  logic [AW-1:0]       alu_rem_hdr;
  logic [AW-1:0]       alu_rem_size;

  logic                accept;
  logic                do_split;
  logic                last_entry;
  logic                out_free;
  logic [NW-1:0]       idx_inc;
  logic [NW-1:0]       jdx_dec;

  assign ent_hdr  = ram_rdata[EW-1 -: AW];
  assign ent_size = ram_rdata[AW:1];
  assign ent_used = ram_rdata[0];

  assign accept     = s_tvalid && s_tready;
  assign idx_inc    = idx + NW'(1);
  assign jdx_dec    = jdx - NW'(1);
  assign last_entry = idx_inc == count;
  assign do_split   = (kind_r == KIND_ALLOC) && verdict.split && (count < NW'(MAX_BLOCKS));
  assign out_free   = !m_tvalid || m_tready;

  ffba_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffba_alu #(
    .AW           (AW),
    .CW           (CW),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_alu (
    .kind     (kind_r),
    .hdr      (ent_hdr),
    .size     (ent_size),
    .used     (ent_used),
    .req      (req_r),
    .reqh     (reqh_r),
    .need     (need_r),
    .tgt      (tgt_r),
    .tgt_ok   (tgt_ok_r),
    .verdict  (verdict),
    .grant    (alu_grant),
    .rem_hdr  (alu_rem_hdr),
    .rem_size (alu_rem_size)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:     state_next = S_IDLE;
      S_IDLE:     if (accept) state_next = S_SRCH_RD;
      S_SRCH_RD:  state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (verdict.hit) begin
          if (do_split) begin
            // shift only when blocks sit above the hit
            state_next = (count > idx_inc) ? S_SH_RD : S_WR_REM;
          end else begin
            state_next = S_RESP;
          end
        end else begin
          state_next = last_entry ? S_RESP : S_SRCH_RD;
        end
      end
      S_SH_RD:    state_next = S_SH_WR;
      S_SH_WR:    state_next = (jdx_dec == idx_inc) ? S_WR_REM : S_SH_RD;
      S_WR_REM:   state_next = S_RESP;
      S_RESP:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_INIT;
    endcase
  end

  // Table port and handshake outputs
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = idx[IW-1:0];
    case (state)
      S_INIT: begin
        // seed entry 0 with one free block over the whole arena
        ram_we    = 1'b1;
        ram_wdata = {AW'(0), AW'(ARENA_BYTES - HEADER_BYTES), 1'b0};
      end
      S_IDLE:     s_tready = 1'b1;
      S_SRCH_RD:  ram_raddr = idx[IW-1:0];
      S_SRCH_CMP: begin
        if (verdict.hit) begin
          ram_we    = 1'b1;
          ram_waddr = idx[IW-1:0];
          if (kind_r == KIND_FREE) begin
            ram_wdata = {ent_hdr, ent_size, 1'b0};
          end else if (do_split) begin
            ram_wdata = {ent_hdr, req_r[AW-1:0], 1'b1};
          end else begin
            ram_wdata = {ent_hdr, ent_size, 1'b1};
          end
        end
      end
      S_SH_RD:    ram_raddr = jdx_dec[IW-1:0];
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = jdx[IW-1:0];
        ram_wdata = ram_rdata;
      end
      S_WR_REM: begin
        ram_we    = 1'b1;
        ram_waddr = idx_inc[IW-1:0];
        ram_wdata = rem_r;
      end
      S_RESP:     ;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT) begin
        count <= NW'(1);
      end
      if (state == S_WR_REM) begin
        count <= count + NW'(1);
      end
      // drop the result once taken, load a fresh one when the slot is free
      if (state == S_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= s_tuser;
      req_r    <= CW'(s_tdata[SIZE_W-1:0]);
      reqh_r   <= CW'(s_tdata[SIZE_W-1:0]) + CW'(HEADER_BYTES);
      need_r   <= CW'(s_tdata[SIZE_W-1:0]) + CW'(HEADER_BYTES + MIN_SPLIT_BYTES);
      tgt_r    <= CW'(s_tdata[2*SIZE_W-1:SIZE_W]) - CW'(HEADER_BYTES);
      tgt_ok_r <= CW'(s_tdata[2*SIZE_W-1:SIZE_W]) >= CW'(HEADER_BYTES);
      idx      <= '0;
    end
    if (state == S_SRCH_CMP) begin
      if (verdict.hit) begin
        rem_r <= {alu_rem_hdr, alu_rem_size, 1'b0};
        jdx   <= count;
        if (kind_r == KIND_FREE) begin
          status_r <= ST_FREED;
          grant_r  <= '0;
        end else begin
          status_r <= ST_GRANT;
          grant_r  <= alu_grant[SIZE_W-1:0];
        end
      end else begin
        idx <= idx_inc;
        if (last_entry) begin
          status_r <= (kind_r == KIND_FREE) ? ST_BADOFF : ST_NOFIT;
          grant_r  <= '0;
        end
      end
    end
    if (state == S_SH_WR) begin
      jdx <= jdx_dec;
    end
    if (state == S_RESP && out_free) begin
      m_tdata <= {(OUT_W - SIZE_W - STATUS_W)'(0), grant_r, status_r};
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_INIT) |-> (count >= NW'(1)) && (count <= NW'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_REM) |=> (count == $past(count) + NW'(1)))
    else $error("block count did not grow by one on split");

  a_shift_above_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SH_WR) |-> (jdx > idx_inc))
    else $error("shift sweep reached the hit block");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("accepted a word while a request is in work");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_RESP))
    else $error("result raised outside the response state");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for first_fit_block_allocator_unit: directed table, then random traffic.
// Depends on ffba_pkg and the allocator RTL; keeps its own block table to predict each word.
`timescale 1ns / 100ps

module tb_top;
  import ffba_pkg::*;

  // Sizing mirrors the default parameters of the block under test
  localparam int ARENA      = ARENA_BYTES_DEF;
  localparam int HDR        = HEADER_BYTES_DEF;
  localparam int MIN_SPLIT  = MIN_SPLIT_BYTES_DEF;
  localparam int MAX_BLK    = MAX_BLOCKS_DEF;
  localparam int SPLIT_NEED = HDR + MIN_SPLIT;

  localparam int N_DIR       = 24;
  localparam int N_RANDOM    = 650;
  localparam int IDLE_PCT    = 23;
  localparam int DRAIN       = 300;   // a full table walk plus a full shift
  localparam int STALL_LIMIT = 3000;  // cycles with no word moving on either side

  // Result word as it sits in m_tdata[12:0]: status low, grant offset above
  typedef struct packed {
    logic [SIZE_W-1:0]   grant;
    logic [STATUS_W-1:0] status;
  } reply_t;

  typedef struct {
    logic              kind;
    logic [SIZE_W-1:0] req;
    logic [SIZE_W-1:0] off;
    bit                pinned;  // expected word typed in below
    logic [STATUS_W-1:0] st;
    logic [SIZE_W-1:0] grant;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;    // req_size[10:0], release_offset[21:11], zero pad
  logic                s_tuser = 1'b0;  // kind
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;         // status[1:0], grant_offset[12:2], zero pad

  bit                  calm = 1'b0;     // both sides stream without idling while set
  int                  errors = 0;
  int                  quiet = 0;
  reply_t              reply_q[$];      // expected result words, oldest first

  // Shadow block table: header offset, data size and in-use mark per block
  int unsigned         arena_hdr [MAX_BLK];
  int unsigned         arena_size[MAX_BLK];
  bit                  arena_used[MAX_BLK];
  int                  arena_blocks;

  stim_row_t           plan[N_DIR];

  first_fit_block_allocator_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Apply one request to the shadow table and return the word the block must answer
  function automatic reply_t allocator_step(input logic kind, input logic [SIZE_W-1:0] req,
                                            input logic [SIZE_W-1:0] off);
    reply_t r;
    bit     done;
    int     i;
    int     j;
    r = '0;
    done = 1'b0;
    if (kind == KIND_ALLOC) begin
      r.status = ST_NOFIT;
      for (i = 0; i < arena_blocks && !done; i++) begin
        if (!arena_used[i] && arena_size[i] >= req) begin
          done = 1'b1;
          arena_used[i] = 1'b1;
          // cut the block when the leftover can carry a header and a minimum payload
          if (arena_size[i] >= req + SPLIT_NEED && arena_blocks < MAX_BLK) begin
            for (j = arena_blocks; j > i + 1; j--) begin
              arena_hdr[j]  = arena_hdr[j-1];
              arena_size[j] = arena_size[j-1];
              arena_used[j] = arena_used[j-1];
            end
            arena_hdr[i+1]  = arena_hdr[i] + HDR + req;
            arena_size[i+1] = arena_size[i] - req - HDR;
            arena_used[i+1] = 1'b0;
            arena_size[i]   = req;
            arena_blocks++;
          end
          r.status = ST_GRANT;
          r.grant  = SIZE_W'(arena_hdr[i] + HDR);
        end
      end
    end else begin
      r.status = ST_BADOFF;
      for (i = 0; i < arena_blocks && !done; i++) begin
        if (arena_hdr[i] + HDR == off) begin
          done = 1'b1;
          arena_used[i] = 1'b0;
          r.status = ST_FREED;
        end
      end
    end
    return r;
  endfunction

  // Random block index whose in-use mark matches; a used pick falls back to any block
  function automatic int pick_block(input bit want_used);
    int idx;
    int c;
    int n;
    idx = -1;
    c = 0;
    for (n = 0; n < 8 && idx < 0; n++) begin
      c = $urandom_range(0, arena_blocks - 1);
      if (arena_used[c] == want_used) idx = c;
    end
    if (idx < 0 && want_used) idx = c;
    return idx;
  endfunction

  // Present one word, hold it until taken, then record what must come back
  task automatic send_word(input logic kind, input logic [SIZE_W-1:0] req,
                           input logic [SIZE_W-1:0] off, input bit pinned,
                           input logic [STATUS_W-1:0] st, input logic [SIZE_W-1:0] grant);
    reply_t r;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, off, req};
    do @(posedge clk); while (!s_tready);
    r = allocator_step(kind, req, off);
    if (pinned) begin
      r.status = st;
      r.grant  = grant;
    end
    reply_q.push_back(r);
  endtask

  // Drop valid now and then so gaps land on every phase of a search
  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin
    int k;
    int m;
    int pick;
    logic kind;
    logic [SIZE_W-1:0] req;
    logic [SIZE_W-1:0] off;

    for (k = 0; k < MAX_BLK; k++) begin
      arena_hdr[k]  = 0;
      arena_size[k] = 0;
      arena_used[k] = 1'b0;
    end
    arena_size[0] = ARENA - HDR;
    arena_blocks  = 1;

    // kind, req_size, release_offset, typed?, status, grant_offset
    plan = '{
      // free of the reset block, then offsets that start no block
      '{KIND_FREE,  11'd2047, 11'd32,   1'b1, ST_FREED,  11'd0},
      '{KIND_FREE,  11'd0,    11'd0,    1'b1, ST_BADOFF, 11'd0},
      '{KIND_FREE,  11'd0,    11'd2047, 1'b1, ST_BADOFF, 11'd0},
      // largest request cannot fit; whole-arena request takes the block unsplit
      '{KIND_ALLOC, 11'd2047, 11'd2047, 1'b1, ST_NOFIT,  11'd0},
      '{KIND_ALLOC, 11'd2016, 11'd0,    1'b1, ST_GRANT,  11'd32},
      '{KIND_ALLOC, 11'd0,    11'd0,    1'b1, ST_NOFIT,  11'd0},
      // free, then free the same free block again
      '{KIND_FREE,  11'd0,    11'd32,   1'b1, ST_FREED,  11'd0},
      '{KIND_FREE,  11'd0,    11'd32,   1'b1, ST_FREED,  11'd0},
      // zero-byte request splits off a 1984-byte remainder
      '{KIND_ALLOC, 11'd0,    11'd0,    1'b1, ST_GRANT,  11'd32},
      '{KIND_ALLOC, 11'd1985, 11'd0,    1'b1, ST_NOFIT,  11'd0},
      '{KIND_ALLOC, 11'd1984, 11'd0,    1'b1, ST_GRANT,  11'd64},
      '{KIND_ALLOC, 11'd0,    11'd0,    1'b1, ST_NOFIT,  11'd0},
      '{KIND_FREE,  11'd0,    11'd64,   1'b1, ST_FREED,  11'd0},
      '{KIND_FREE,  11'd0,    11'd63,   1'b1, ST_BADOFF, 11'd0},
      '{KIND_ALLOC, 11'd1000, 11'd1365, 1'b1, ST_GRANT,  11'd64},
      // fit without split, split right at the boundary, exact fit of the remainder
      '{KIND_ALLOC, 11'd1,    11'd0,    1'b0, ST_GRANT,  11'd0},
      '{KIND_ALLOC, 11'd918,  11'd0,    1'b0, ST_GRANT,  11'd0},
      '{KIND_FREE,  11'd0,    11'd1129, 1'b0, ST_GRANT,  11'd0},
      '{KIND_ALLOC, 11'd871,  11'd0,    1'b0, ST_GRANT,  11'd0},
      '{KIND_ALLOC, 11'd16,   11'd0,    1'b0, ST_GRANT,  11'd0},
      '{KIND_FREE,  11'd1234, 11'd1096, 1'b0, ST_GRANT,  11'd0},
      '{KIND_ALLOC, 11'd0,    11'd682,  1'b0, ST_GRANT,  11'd0},
      '{KIND_ALLOC, 11'd2047, 11'd0,    1'b1, ST_NOFIT,  11'd0},
      '{KIND_FREE,  11'd0,    11'd1,    1'b1, ST_BADOFF, 11'd0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < N_DIR; k++) begin
      send_word(plan[k].kind, plan[k].req, plan[k].off, plan[k].pinned, plan[k].st,
                plan[k].grant);
      maybe_idle();
    end

    // Random traffic: mostly allocs of small sizes and frees of live offsets
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == 250) calm <= 1'b1;
      if (k == 350) calm <= 1'b0;
      // the unused field carries noise
      req = SIZE_W'($urandom_range(0, 2047));
      off = SIZE_W'($urandom_range(0, 2047));
      m = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 55) begin
        kind = KIND_ALLOC;
        if (m < 45) req = SIZE_W'($urandom_range(0, 48));
        else if (m < 70) req = SIZE_W'($urandom_range(49, 400));
        else if (m < 78) req = SIZE_W'($urandom_range(401, 2047));
        else begin
          // hit a free block exactly, or right at its split boundary
          pick = pick_block(1'b0);
          if (pick < 0) req = SIZE_W'($urandom_range(0, 48));
          else if (m < 90) req = SIZE_W'(arena_size[pick]);
          else if (arena_size[pick] >= SPLIT_NEED) req = SIZE_W'(arena_size[pick] - SPLIT_NEED);
          else req = SIZE_W'(arena_size[pick]);
        end
      end else begin
        kind = KIND_FREE;
        pick = pick_block(m < 55);
        if (m < 85 && pick >= 0) begin
          off = SIZE_W'(arena_hdr[pick] + HDR);
          // near misses one byte off a real block
          if (m >= 70) off = $urandom_range(0, 1) ? off + 11'd1 : off - 11'd1;
        end
      end
      send_word(kind, req, off, 1'b0, ST_GRANT, 11'd0);
      maybe_idle();
    end

    s_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("first_fit_block_allocator_unit test passed");
    end else begin
      $display("first_fit_block_allocator_unit test failed");
    end
    $finish;
  end

  // Receiver: back-pressure at random except in the calm stretch
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    reply_t seen;
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata[12:0];
      if (reply_q.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d offset %0d",
                 $time, seen.status, seen.grant);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (seen.status != want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, seen.status);
          errors++;
        end
        if (seen.grant != want.grant) begin
          $display("%0t: grant_offset mismatch: expected %0d, got %0d",
                   $time, want.grant, seen.grant);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("first_fit_block_allocator_unit test failed");
      $finish;
    end
  end

endmodule

[sim.f]
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/ffba_alu.sv
hdl/first_fit_block_allocator_unit.sv
tb/tb_top.sv
